/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL that checks itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check
`define MBS_ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, reset masks the check
`define MBS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle rule");

`endif

/* rtl/core/mbslv_pkg.sv */
// Shared types, constants and CRC helper for the Modbus RTU sensor slave
package mbslv_pkg;

    localparam int FRAME_BYTES_DEF = 32;

    localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
    localparam logic [7:0]  FUNC_READ      = 8'h03;
    localparam logic [7:0]  FUNC_WRITE     = 8'h06;
    localparam logic [7:0]  EXC_READ       = 8'h83;
    localparam logic [7:0]  EXC_WRITE      = 8'h86;
    localparam logic [7:0]  EXC_FUNC       = 8'h80;
    localparam logic [7:0]  ALT_BASE_HI    = 8'h40;
    localparam logic [7:0]  EXC_CODE_ADDR  = 8'h02;
    localparam logic [7:0]  EXC_CODE_FUNC  = 8'h01;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;

    typedef struct packed {
        logic               op;
        logic [7:0]         rx_byte;
        logic signed [15:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        pm25_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_UPD,
        ST_DECIDE,
        ST_TX_RD,
        ST_TX_LD,
        ST_TX_WAIT
    } state_t;

    typedef struct packed {
        logic byte_wr;
        logic eof;
        logic walk_rd;
        logic walk_upd;
        logic decide;
        logic tx_rd;
        logic tx_ld;
        logic tx_next;
    } dp_cmd_t;

    typedef struct packed {
        logic drop_early;
        logic walk_done;
        logic frame_ok;
        logic out_taken;
        logic out_last;
    } dp_status_t;

    // Fold one byte into the Modbus CRC-16, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/modbus_rtu_sensor_slave_unit.sv */
// Top level of the Modbus RTU sensor slave: sequencer plus datapath
// Usage:
//   s_ channel: one word per received byte (op 0) or an end-of-frame marker
//   (op 1) that also samples the three sensor readings.
//   m_ channel: reply bytes, CRC low then high last, with last set on the
//   final byte. cfg_ channel: writes the station address (always ready).
// Sequence:
//   A received byte is written into the buffer when taken. At end of frame
//   the buffer is walked, a read then an update for each stored byte,
//   through the single read port and the byte-wide CRC unit; the walk end
//   is then seen and the frame decoded. Each reply byte then goes through
//   read, load and hand-over steps, plus any receiver stall.
//   Input is not accepted while a frame is being checked or answered.
//   Frames that fail address or CRC checks, are shorter than 4 bytes or
//   overflow the buffer produce no reply.
// Reset: the station address returns to 1, the byte count, overflow flag
//   and register bank clear; buffer contents are left as they were.
// Stall: m_valid and the reply byte hold until m_ready is seen.
module modbus_rtu_sensor_slave_unit #(
    parameter int FRAME_BYTES = mbslv_pkg::FRAME_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mbslv_pkg::in_word_t  s_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mbslv_pkg::out_word_t m_word
);
    import mbslv_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    mbslv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_word.op),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    mbslv_dp #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_wdata (cfg_wdata),
        .s_word    (s_word),
        .cmd       (cmd),
        .st        (st),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    // Input is never taken while a reply byte is pending
    `MBS_ASSERT_SAME(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // Final reply byte handed over: the output goes quiet next cycle
    `MBS_ASSERT_NEXT(a_last_ends, aclk, aresetn, m_valid && m_ready && m_word.last, !m_valid)
    // A plain received byte never starts frame processing
    `MBS_ASSERT_NEXT(a_byte_stays_idle, aclk, aresetn, s_valid && s_ready && !s_word.op, s_ready)

endmodule

/* rtl/core/mbslv_ctrl.sv */
// Sequencer for frame capture, frame check and reply emission
module mbslv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_op,
    output logic                s_ready,
    input  mbslv_pkg::dp_status_t st,
    output mbslv_pkg::dp_cmd_t  cmd
);
    import mbslv_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op && !st.drop_early) begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = st.walk_done ? ST_DECIDE : ST_WALK_UPD;
            end
            ST_WALK_UPD: state_next = ST_WALK_RD;
            ST_DECIDE: begin
                state_next = st.frame_ok ? ST_TX_RD : ST_IDLE;
            end
            ST_TX_RD: state_next = ST_TX_LD;
            ST_TX_LD: state_next = ST_TX_WAIT;
            ST_TX_WAIT: begin
                if (st.out_taken) begin
                    state_next = st.out_last ? ST_IDLE : ST_TX_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.byte_wr = s_valid && !s_op;
                cmd.eof     = s_valid && s_op;
            end
            ST_WALK_RD:  cmd.walk_rd  = !st.walk_done;
            ST_WALK_UPD: cmd.walk_upd = 1'b1;
            ST_DECIDE:   cmd.decide   = st.frame_ok;
            ST_TX_RD:    cmd.tx_rd    = 1'b1;
            ST_TX_LD:    cmd.tx_ld    = 1'b1;
            ST_TX_WAIT:  cmd.tx_next  = st.out_taken;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/mbslv_dp.sv */
// Frame buffer, CRC unit, frame decode and reply byte path
module mbslv_dp #(
    parameter int FRAME_BYTES = mbslv_pkg::FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [7:0]            cfg_wdata,
    input  mbslv_pkg::in_word_t   s_word,
    input  mbslv_pkg::dp_cmd_t    cmd,
    output mbslv_pkg::dp_status_t st,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mbslv_pkg::out_word_t  m_word
);
    import mbslv_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int KW = $clog2(FRAME_BYTES + 2);

    logic [7:0]    mem [FRAME_BYTES];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    logic [7:0]    slave_addr_reg;
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg;
    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic [7:0]    b0_reg, fn_reg, hi_reg, lo_reg, qty_reg, rxlo_reg, rxhi_reg;
    logic [15:0]   temp_reg, hum_reg, pm_reg;
    logic [7:0]    bank_reg [5];

    logic          from_buf_reg;
    logic [KW-1:0] blen_reg;
    logic [7:0]    code_reg, third_reg;
    logic [1:0]    sel_reg;
    logic [KW-1:0] k_reg;

    out_word_t     out_reg;
    out_word_t     out_next;
    logic          m_valid_reg;

    // Decode of the captured request
    logic          echo_rd, rd_ok, wr_ok, single, triple;
    logic [7:0]    base;
    logic [KW-1:0] dlen, blen_next;
    logic [7:0]    code_next, third_next;
    logic [1:0]    sel_next;

    always_comb begin
        echo_rd = (fn_reg == FUNC_READ) && (hi_reg == 8'h00) && (lo_reg == 8'd5);
        rd_ok   = (fn_reg == FUNC_READ) &&
                  (((hi_reg == 8'h00) && (lo_reg <= 8'd4)) ||
                   ((hi_reg == ALT_BASE_HI) && (lo_reg <= 8'd5)));
        wr_ok   = (fn_reg == FUNC_WRITE) && (hi_reg == 8'h00) && (lo_reg <= 8'd5);
        base    = (hi_reg == 8'h00) ? 8'd1 : 8'd2;
        single  = (lo_reg >= base) && (lo_reg <= base + 8'd2) && (qty_reg == 8'd1);
        triple  = (lo_reg == base) && (qty_reg == 8'd3);
        dlen    = single ? KW'(2) : (triple ? KW'(6) : KW'(0));
        sel_next = single ? 2'(lo_reg - base) : 2'd0;
        if (echo_rd) begin
            blen_next = KW'(n_reg);
        end else if (wr_ok) begin
            blen_next = KW'(n_reg - CW'(2));
        end else begin
            // sensor data only follows a valid read header
            blen_next = KW'(3) + (rd_ok ? dlen : KW'(0));
        end
        if (rd_ok) begin
            code_next  = FUNC_READ;
            third_next = {qty_reg[6:0], 1'b0};
        end else if (fn_reg == FUNC_READ) begin
            code_next  = EXC_READ;
            third_next = EXC_CODE_ADDR;
        end else if (fn_reg == FUNC_WRITE) begin
            code_next  = EXC_WRITE;
            third_next = EXC_CODE_ADDR;
        end else begin
            code_next  = EXC_FUNC;
            third_next = EXC_CODE_FUNC;
        end
    end

    // Buffer read port
    always_comb begin
        rd_en   = cmd.walk_rd || (cmd.tx_rd && from_buf_reg && (k_reg < blen_reg));
        rd_addr = cmd.walk_rd ? i_reg[AW-1:0] : k_reg[AW-1:0];
    end

    // Buffer memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.byte_wr && (cnt_reg < CW'(FRAME_BYTES))) begin
            mem[cnt_reg[AW-1:0]] <= s_word.rx_byte;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Reply byte and running CRC
    logic [KW-1:0] d;
    logic [1:0]    widx;
    logic [15:0]   word;
    logic [7:0]    body_byte;

    always_comb begin
        d    = k_reg - KW'(3);
        widx = sel_reg + d[2:1];
        case (widx)
            2'd0:    word = temp_reg;
            2'd1:    word = hum_reg;
            default: word = pm_reg;
        endcase
        if (from_buf_reg) begin
            body_byte = rdata_reg;
        end else if (k_reg == KW'(0)) begin
            body_byte = b0_reg;
        end else if (k_reg == KW'(1)) begin
            body_byte = code_reg;
        end else if (k_reg == KW'(2)) begin
            body_byte = third_reg;
        end else begin
            body_byte = d[0] ? word[7:0] : word[15:8];
        end
        crc_next = crc_reg;
        if (k_reg < blen_reg) begin
            out_next = '{tx_byte: body_byte, last: 1'b0};
            crc_next = crc16_byte(crc_reg, body_byte);
        end else if (k_reg == blen_reg) begin
            out_next = '{tx_byte: crc_reg[7:0], last: 1'b0};
        end else begin
            out_next = '{tx_byte: crc_reg[15:8], last: 1'b1};
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_ADDR_RST;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int j = 0; j < 5; j++) begin
                bank_reg[j] <= 8'h00;
            end
        end else begin
            if (cfg_valid) begin
                slave_addr_reg <= cfg_wdata;
            end
            // count bytes, flag overflow
            if (cmd.byte_wr) begin
                if (cnt_reg < CW'(FRAME_BYTES)) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.eof) begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
            end
            // store a written register
            if (cmd.decide && wr_ok && (lo_reg <= 8'd4)) begin
                bank_reg[lo_reg[2:0]] <= qty_reg;
            end
            if (cmd.tx_ld) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: frame walk, capture and reply state
    always_ff @(posedge aclk) begin
        if (cmd.eof) begin
            n_reg    <= cnt_reg;
            i_reg    <= '0;
            crc_reg  <= CRC_INIT;
            qty_reg  <= 8'h00;
            temp_reg <= s_word.temperature_centi;
            hum_reg  <= {2'b00, s_word.humidity_centi};
            pm_reg   <= s_word.pm25_value;
        end
        if (cmd.walk_upd) begin
            if (i_reg < n_reg - CW'(2)) begin
                crc_reg <= crc16_byte(crc_reg, rdata_reg);
            end
            if (i_reg == CW'(0)) b0_reg  <= rdata_reg;
            if (i_reg == CW'(1)) fn_reg  <= rdata_reg;
            if (i_reg == CW'(2)) hi_reg  <= rdata_reg;
            if (i_reg == CW'(3)) lo_reg  <= rdata_reg;
            if (i_reg == CW'(5)) qty_reg <= rdata_reg;
            if (i_reg == n_reg - CW'(2)) rxlo_reg <= rdata_reg;
            if (i_reg == n_reg - CW'(1)) rxhi_reg <= rdata_reg;
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.decide) begin
            from_buf_reg <= echo_rd || wr_ok;
            blen_reg     <= blen_next;
            code_reg     <= code_next;
            third_reg    <= third_next;
            sel_reg      <= sel_next;
            k_reg        <= '0;
            crc_reg      <= CRC_INIT;
        end
        if (cmd.tx_ld) begin
            out_reg <= out_next;
            crc_reg <= crc_next;
        end
        if (cmd.tx_next) begin
            k_reg <= k_reg + KW'(1);
        end
    end

    // Status to the sequencer
    always_comb begin
        st.drop_early = ovf_reg || (cnt_reg < CW'(4));
        st.walk_done  = (i_reg == n_reg);
        st.frame_ok   = (b0_reg == slave_addr_reg) &&
                        (rxlo_reg == crc_reg[7:0]) && (rxhi_reg == crc_reg[15:8]);
        st.out_taken  = m_valid_reg && m_ready;
        st.out_last   = out_reg.last;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = out_reg;

endmodule

/* verif/tb_modbus_rtu_sensor_slave_unit.sv */
// Testbench for the Modbus RTU sensor slave: directed and random frames checked against a behavioral model
module tb_modbus_rtu_sensor_slave_unit;
    import mbslv_pkg::*;

    localparam int NBUF = 32;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_wdata = 8'h00;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_word;

    modbus_rtu_sensor_slave_unit #(.FRAME_BYTES(NBUF)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_word(s_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(m_word)
    );

    always #2 aclk = ~aclk;

    // Model state
    logic [7:0] rx_buf [NBUF];
    int unsigned rx_cnt;
    bit rx_ovf;
    logic [7:0] regs [5];
    logic [7:0] station;

    in_word_t word_q [$];
    out_word_t reply_q [$];
    logic [7:0] cfg_q [$];

    int errors = 0;
    int bytes_seen = 0;
    int frames_answered = 0;
    bit calm = 1'b0;
    int s_gap = 0;
    int m_gap = 0;

    function automatic logic [15:0] crc_of(input logic [7:0] b [$]);
        logic [15:0] r;
        r = 16'hFFFF;
        foreach (b[i]) begin
            r ^= {8'h00, b[i]};
            for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    // Advance the model by one accepted word and queue the reply bytes
    task automatic model_word(input in_word_t w);
        logic [7:0] fr [$];
        logic [7:0] rb [$];
        logic [7:0] fn, hi, lo, cnt;
        logic [15:0] c;
        logic [15:0] sens [3];
        int unsigned n, base;
        if (!w.op) begin
            if (rx_cnt < NBUF) begin
                rx_buf[rx_cnt] = w.rx_byte;
                rx_cnt++;
            end else rx_ovf = 1'b1;
            return;
        end
        n = rx_cnt;
        rx_cnt = 0;
        if (rx_ovf || n < 4) begin
            rx_ovf = 1'b0;
            return;
        end
        for (int i = 0; i < n; i++) fr.push_back(rx_buf[i]);
        if (fr[0] != station) return;
        c = crc_of(fr[0:n-3]);
        if (fr[n-2] != c[7:0] || fr[n-1] != c[15:8]) return;
        fn = fr[1];
        hi = fr[2];
        lo = fr[3];
        cnt = (n > 5) ? fr[5] : 8'h00;
        sens[0] = w.temperature_centi;
        sens[1] = {2'b00, w.humidity_centi};
        sens[2] = w.pm25_value;
        rb.push_back(fr[0]);
        if (fn == FUNC_READ) begin
            if (hi == 8'h00 && lo == 8'd5) begin
                rb = fr;
            end else if ((hi == 8'h00 && lo <= 4) || (hi == ALT_BASE_HI && lo <= 5)) begin
                base = (hi == 8'h00) ? 1 : 2;
                rb.push_back(FUNC_READ);
                rb.push_back(8'(cnt * 2));
                if (lo >= base && lo <= base + 2 && cnt == 1) begin
                    rb.push_back(sens[lo-base][15:8]);
                    rb.push_back(sens[lo-base][7:0]);
                end else if (lo == base && cnt == 3) begin
                    for (int i = 0; i < 3; i++) begin
                        rb.push_back(sens[i][15:8]);
                        rb.push_back(sens[i][7:0]);
                    end
                end
            end else begin
                rb.push_back(EXC_READ);
                rb.push_back(EXC_CODE_ADDR);
            end
        end else if (fn == FUNC_WRITE) begin
            if (hi == 8'h00 && lo <= 5) begin
                if (lo <= 4) regs[lo] = cnt;
                rb = fr[0:n-3];
            end else begin
                rb.push_back(EXC_WRITE);
                rb.push_back(EXC_CODE_ADDR);
            end
        end else begin
            rb.push_back(EXC_FUNC);
            rb.push_back(EXC_CODE_FUNC);
        end
        c = crc_of(rb);
        rb.push_back(c[7:0]);
        rb.push_back(c[15:8]);
        foreach (rb[i]) reply_q.push_back('{tx_byte: rb[i], last: (i == rb.size() - 1)});
        frames_answered++;
    endtask

    // Drive input words from the pending queue, with random idle bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                model_word(s_word);
                void'(word_q.pop_front());
            end
            if (s_valid && !(s_valid && s_ready)) begin
                // hold word
            end else if (s_gap > 0) begin
                s_gap <= s_gap - 1;
                s_valid <= 1'b0;
            end else if ((s_valid && s_ready ? word_q.size() > 0 : word_q.size() > 0)) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    s_gap <= $urandom_range(1, 19);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_word <= word_q[0];
                end
            end else s_valid <= 1'b0;
        end
    end

    // Check reply words and stall the receiver in bursts
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                bytes_seen++;
                if (reply_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected reply byte %02h last %0b",
                        m_word.tx_byte, m_word.last);
                end else begin
                    if (m_word.tx_byte !== reply_q[0].tx_byte || m_word.last !== reply_q[0].last) begin
                        errors++;
                        if (errors <= 10) $display("reply mismatch: exp %02h/%0b got %02h/%0b",
                            reply_q[0].tx_byte, reply_q[0].last, m_word.tx_byte, m_word.last);
                    end
                    void'(reply_q.pop_front());
                end
            end
            if (m_gap > 0) begin
                m_gap <= m_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                m_gap <= $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    // Apply station address writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                station = cfg_wdata;
                void'(cfg_q.pop_front());
            end
            if (cfg_valid && !cfg_ready) begin
                // hold word
            end else if (cfg_q.size() > (cfg_valid && cfg_ready ? 0 : 0)) begin
                cfg_valid <= 1'b1;
                cfg_wdata <= cfg_q[0];
            end else cfg_valid <= 1'b0;
        end
    end

    function automatic in_word_t rx(input logic [7:0] b);
        in_word_t w;
        w = '0;
        w.op = 1'b0;
        w.rx_byte = b;
        w.temperature_centi = 16'($urandom);
        w.humidity_centi = 14'($urandom);
        w.pm25_value = 16'($urandom);
        return w;
    endfunction

    // Queue a frame: body, optional good CRC (or corrupted), then end marker
    task automatic push_frame(input logic [7:0] body [$], input bit good_crc,
                              input bit rand_sens);
        logic [15:0] c;
        in_word_t e;
        c = crc_of(body);
        if (!good_crc) c ^= 16'h0001 << $urandom_range(0, 15);
        foreach (body[i]) word_q.push_back(rx(body[i]));
        word_q.push_back(rx(c[7:0]));
        word_q.push_back(rx(c[15:8]));
        e = rx(8'h00);
        e.op = 1'b1;
        e.rx_byte = 8'($urandom);
        if (!rand_sens) begin
            e.temperature_centi = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
            e.humidity_centi = ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'd10000;
            e.pm25_value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end else if ($urandom_range(0, 3) == 0) e.humidity_centi = 14'($urandom_range(0, 10000));
        word_q.push_back(e);
    endtask

    task automatic push_eof();
        in_word_t e;
        e = rx(8'h00);
        e.op = 1'b1;
        word_q.push_back(e);
    endtask

    task automatic req(input logic [7:0] a, input logic [7:0] f, input logic [7:0] h,
                       input logic [7:0] l, input logic [7:0] ch, input logic [7:0] cl,
                       input bit good_crc);
        logic [7:0] body [$];
        body = '{a, f, h, l, ch, cl};
        push_frame(body, good_crc, 1'b1);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((word_q.size() > 0 || s_valid || reply_q.size() > 0 || cfg_q.size() > 0
                || cfg_valid) && guard < 400000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
    endtask

    // Random frame mostly well formed, sometimes noise or broken
    task automatic random_frame(input logic [7:0] a);
        logic [7:0] body [$];
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            case ($urandom_range(0, 5))
                0: req(a, FUNC_READ, 8'h00, 8'($urandom_range(0, 6)), 8'h00,
                       8'($urandom_range(0, 4)), 1);
                1: req(a, FUNC_READ, ALT_BASE_HI, 8'($urandom_range(0, 6)), 8'($urandom),
                       8'($urandom_range(0, 4)), 1);
                2: req(a, FUNC_WRITE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
                       8'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 1);
                3: req(a, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 1);
                4: req(a, FUNC_READ, 8'h00, 8'h05, 8'($urandom), 8'($urandom), 1);
                default: begin
                    body.push_back(a);
                    body.push_back(($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE);
                    repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
                    push_frame(body, 1'b1, 1'b1);
                end
            endcase
        end else if (kind < 16) begin
            req(a, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h01, 0);
        end else if (kind < 17) begin
            req(a + 8'd1, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h01, 1);
        end else if (kind < 19) begin
            repeat ($urandom_range(0, 3)) word_q.push_back(rx(8'($urandom)));
            push_eof();
        end else begin
            repeat ($urandom_range(NBUF + 1, NBUF + 3)) word_q.push_back(rx(8'($urandom)));
            push_eof();
        end
    endtask

    initial begin
        logic [7:0] addrs [4];
        int phase;
        station = SLAVE_ADDR_RST;
        rx_cnt = 0;
        rx_ovf = 1'b0;
        foreach (regs[i]) regs[i] = 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames, addressed mostly to the reset address
        req(8'h01, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h01, 1);
        push_frame('{8'h01, FUNC_READ, 8'h00, 8'h02, 8'h00, 8'h01}, 1'b1, 1'b0);
        push_frame('{8'h01, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h03}, 1'b1, 1'b0);
        push_frame('{8'h01, FUNC_READ, ALT_BASE_HI, 8'h02, 8'h00, 8'h03}, 1'b1, 1'b0);
        req(8'h01, FUNC_READ, ALT_BASE_HI, 8'h04, 8'h00, 8'h01, 1);
        req(8'h01, FUNC_READ, 8'h00, 8'h05, 8'hFF, 8'hFF, 1);
        req(8'h01, FUNC_READ, 8'h12, 8'h00, 8'h00, 8'h01, 1);
        req(8'h01, FUNC_WRITE, 8'h00, 8'h04, 8'h00, 8'hFF, 1);
        req(8'h01, FUNC_WRITE, 8'h00, 8'h05, 8'h00, 8'h7E, 1);
        req(8'h01, FUNC_WRITE, 8'h00, 8'h09, 8'h00, 8'h01, 1);
        req(8'h01, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 1);
        req(8'h01, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h01, 0);
        req(8'h02, FUNC_READ, 8'h00, 8'h01, 8'h00, 8'h01, 1);
        push_frame('{8'h01, FUNC_READ}, 1'b1, 1'b1);
        word_q.push_back(rx(8'h01));
        word_q.push_back(rx(8'h03));
        push_eof();
        repeat (NBUF + 2) word_q.push_back(rx(8'h01));
        push_eof();
        push_eof();
        drain();

        // Random phases across several station addresses
        addrs = '{8'h00, 8'hFF, 8'hF7, 8'h00};
        addrs[3] = 8'($urandom_range(2, 246));
        for (phase = 0; phase < 4; phase++) begin
            cfg_q.push_back(addrs[phase]);
            drain();
            if (phase == 3) calm = 1'b1;
            repeat (3) random_frame(addrs[phase]);
            drain();
        end
        $display("covered %0d reply frames, %0d reply bytes over 5 station addresses",
                 frames_answered, bytes_seen);
        if (errors == 0 && reply_q.size() == 0) begin
            $display("tb_modbus_rtu_sensor_slave_unit passed");
        end else begin
            $display("%0d mismatches, %0d replies outstanding", errors, reply_q.size());
            $display("tb_modbus_rtu_sensor_slave_unit failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8000000;
        $display("tb_modbus_rtu_sensor_slave_unit failed");
        $finish;
    end

endmodule

/* modbus_rtu_sensor_slave_unit.f */
+incdir+rtl/core
rtl/core/mbslv_pkg.sv
rtl/core/mbslv_ctrl.sv
rtl/core/mbslv_dp.sv
rtl/core/modbus_rtu_sensor_slave_unit.sv
verif/tb_modbus_rtu_sensor_slave_unit.sv
